>>> hdl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

	// default sizing
	localparam int DEF_WINDOW   = 8;
	localparam int DEF_SEQ_BITS = 16;

	// fixed port widths
	localparam int FUNC_W     = 2;
	localparam int PAYLOAD_W  = 64;
	localparam int PORT_SEQ_W = 16;

	// sequence number of the first packet after reset
	localparam int SEQ_INIT = 1;

	// word kinds
	localparam logic [FUNC_W-1:0] FUNC_SEND    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ACK     = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;

	// decision of the window control for one word
	typedef struct packed {
		logic accepted;
		logic packet_valid;
		logic timer_start;
		logic timer_stop;
		logic mem_write;
		logic mem_read;
	} srsw_act_t;

endpackage

>>> hdl/srsw_ctrl.sv
// ----------------------------------------------------------------------------
// srsw_ctrl
// Window bookkeeping: decodes one word against base, next sequence and the
// per-slot valid and acked bits, and works out the slide of the base.
// ----------------------------------------------------------------------------
module srsw_ctrl
	import srsw_pkg::*;
#(
	parameter int WINDOW   = DEF_WINDOW,
	parameter int SEQ_BITS = DEF_SEQ_BITS,
	localparam int SLOT_W  = $clog2(WINDOW)
) (
	input  logic [FUNC_W-1:0]   func,
	input  logic [SEQ_BITS-1:0] seq,
	input  logic                checksum_ok,
	input  logic [SEQ_BITS-1:0] base,
	input  logic [SEQ_BITS-1:0] next,
	input  logic [SLOT_W-1:0]   head,
	input  logic [WINDOW-1:0]   valid,
	input  logic [WINDOW-1:0]   acked,
	output srsw_act_t           act,
	output logic [SLOT_W-1:0]   slot,
	output logic [SEQ_BITS-1:0] base_nxt,
	output logic [SEQ_BITS-1:0] next_nxt,
	output logic [SLOT_W-1:0]   head_nxt,
	output logic [WINDOW-1:0]   valid_nxt,
	output logic [WINDOW-1:0]   acked_nxt
);

	// outstanding packets allowed: the window or half the sequence space
	localparam int HALF  = (SEQ_BITS > 7) ? WINDOW : (1 << (SEQ_BITS - 1));
	localparam int LIMIT = (WINDOW < HALF) ? WINDOW : HALF;

	// slot arithmetic modulo the window, first operand below the window size, second at most the window size
	function automatic logic [SLOT_W-1:0] add_mod(input logic [SLOT_W-1:0] a,
			input logic [SLOT_W:0] b);
		logic [SLOT_W:0] sum;
		sum = {1'b0, a} + b;
		if (sum >= (SLOT_W+1)'(WINDOW)) begin
			sum = sum - (SLOT_W+1)'(WINDOW);
		end
		return sum[SLOT_W-1:0];
	endfunction

	logic [SEQ_BITS-1:0] cnt;
	logic [SEQ_BITS-1:0] off;
	logic                in_win;
	logic                room;
	logic [SLOT_W-1:0]   slot_send;
	logic [SLOT_W-1:0]   slot_off;
	logic [SLOT_W-1:0]   rot_idx [WINDOW];
	logic [WINDOW-1:0]   run;
	logic [SLOT_W:0]     adv;
	logic [WINDOW-1:0]   clr;
	logic [SLOT_W:0]     span;

	// window occupancy and offset of the incoming number
	assign cnt       = next - base;
	assign off       = seq - base;
	assign in_win    = off < cnt;
	assign room      = cnt < SEQ_BITS'(LIMIT);
	assign slot_send = add_mod(head, {1'b0, cnt[SLOT_W-1:0]});
	assign slot_off  = add_mod(head, {1'b0, off[SLOT_W-1:0]});

	// acknowledged slots in window order, counted from the base
	always_comb begin
		for (int j = 0; j < WINDOW; j++) begin
			rot_idx[j] = add_mod(head, (SLOT_W+1)'(j));
			run[j] = valid[rot_idx[j]] & acked[rot_idx[j]] & (SEQ_BITS'(j) < cnt);
		end
	end

	// slide length: base slot plus the run of acknowledged slots behind it
	always_comb begin
		adv = (SLOT_W+1)'(WINDOW);
		for (int j = WINDOW - 1; j >= 1; j--) begin
			if (!run[j]) begin
				adv = (SLOT_W+1)'(j);
			end
		end
	end

	// slots released by the slide
	always_comb begin
		span = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (SLOT_W'(i) >= head) begin
				span = (SLOT_W+1)'(i) - {1'b0, head};
			end else begin
				span = (SLOT_W+1)'(i + WINDOW) - {1'b0, head};
			end
			clr[i] = span < adv;
		end
	end

	// decode of the word
	always_comb begin
		act       = '0;
		slot      = slot_off;
		base_nxt  = base;
		next_nxt  = next;
		head_nxt  = head;
		valid_nxt = valid;
		acked_nxt = acked;
		unique case (func)
			FUNC_SEND: begin
				if (room) begin
					act.accepted     = 1'b1;
					act.packet_valid = 1'b1;
					act.timer_start  = 1'b1;
					act.mem_write    = 1'b1;
					slot             = slot_send;
					valid_nxt[slot_send] = 1'b1;
					acked_nxt[slot_send] = 1'b0;
					next_nxt         = next + SEQ_BITS'(1);
				end
			end
			FUNC_ACK: begin
				if (checksum_ok && in_win) begin
					if (off == '0) begin
						act.timer_stop = 1'b1;
						base_nxt  = base + SEQ_BITS'(adv);
						head_nxt  = add_mod(head, adv);
						valid_nxt = valid & ~clr;
						acked_nxt = acked & ~clr;
					end else if (!acked[slot_off]) begin
						act.timer_stop = 1'b1;
						acked_nxt[slot_off] = 1'b1;
					end
				end
			end
			FUNC_TIMEOUT: begin
				if (in_win && valid[slot_off] && !acked[slot_off]) begin
					act.packet_valid = 1'b1;
					act.timer_start  = 1'b1;
					act.mem_read     = 1'b1;
				end
			end
			default: begin
				act = '0;
			end
		endcase
	end

endmodule

>>> hdl/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender side of a selective-repeat link: keeps the outstanding packets in a
// payload memory, numbers new packets, retires acknowledged ones and resends
// on timeout, with one result word for every input word.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid, in_stall | func, send_payload, seq_num, checksum_ok
//  out     | out_valid,out_stall| accepted, packet_valid, packet_seq,
//          |                    | packet_payload, timer_start, timer_stop,
//          |                    | timer_seq, window_base
//
//  Each word passes two steps: the accept cycle updates the window state and
//  issues the payload memory access, the move into the output register
//  collects the read data; a stalled output delays that move.
//  Reset clears the window at once; the payload memory holds no reset value.
//  in_stall is high while a word waits between the two steps, so a stalled
//  output holds back at most one further word.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window
	import srsw_pkg::*;
#(
	parameter int WINDOW   = DEF_WINDOW,
	parameter int SEQ_BITS = DEF_SEQ_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [FUNC_W-1:0]     func,
	input  logic [PAYLOAD_W-1:0]  send_payload,
	input  logic [PORT_SEQ_W-1:0] seq_num,
	input  logic                  checksum_ok,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  accepted,
	output logic                  packet_valid,
	output logic [PORT_SEQ_W-1:0] packet_seq,
	output logic [PAYLOAD_W-1:0]  packet_payload,
	output logic                  timer_start,
	output logic                  timer_stop,
	output logic [PORT_SEQ_W-1:0] timer_seq,
	output logic [PORT_SEQ_W-1:0] window_base
);

	localparam int SLOT_W = $clog2(WINDOW);
	localparam int HALF   = (SEQ_BITS > 7) ? WINDOW : (1 << (SEQ_BITS - 1));
	localparam int LIMIT  = (WINDOW < HALF) ? WINDOW : HALF;

	// window state
	logic [SEQ_BITS-1:0]   base_q;
	logic [SEQ_BITS-1:0]   next_q;
	logic [SLOT_W-1:0]     head_q;
	logic [WINDOW-1:0]     valid_q;
	logic [WINDOW-1:0]     acked_q;

	// control outputs
	srsw_act_t             act;
	logic [SLOT_W-1:0]     slot;
	logic [SEQ_BITS-1:0]   base_nxt;
	logic [SEQ_BITS-1:0]   next_nxt;
	logic [SLOT_W-1:0]     head_nxt;
	logic [WINDOW-1:0]     valid_nxt;
	logic [WINDOW-1:0]     acked_nxt;

	logic                  accept;
	logic                  move;
	logic [SEQ_BITS-1:0]   seq_w;
	logic [PORT_SEQ_W-1:0] seq16;
	logic [PORT_SEQ_W-1:0] next16;
	logic [PORT_SEQ_W-1:0] num16;
	logic [SEQ_BITS-1:0]   cnt;

	// payload memory
	logic [PAYLOAD_W-1:0]  mem [WINDOW];
	logic [PAYLOAD_W-1:0]  rd_q;

	// stage one
	logic                  valid_s1;
	srsw_act_t             act_s1;
	logic [PORT_SEQ_W-1:0] pseq_s1;
	logic [PORT_SEQ_W-1:0] tseq_s1;
	logic [PORT_SEQ_W-1:0] base_s1;
	logic [PAYLOAD_W-1:0]  payload_s1;

	// output register
	logic                  out_valid_q;
	logic                  accepted_q;
	logic                  packet_valid_q;
	logic [PORT_SEQ_W-1:0] packet_seq_q;
	logic [PAYLOAD_W-1:0]  packet_payload_q;
	logic                  timer_start_q;
	logic                  timer_stop_q;
	logic [PORT_SEQ_W-1:0] timer_seq_q;
	logic [PORT_SEQ_W-1:0] window_base_q;

	// handshake
	assign in_stall = valid_s1;
	assign accept   = in_valid && !in_stall;
	assign move     = valid_s1 && (!out_valid_q || !out_stall);

	// incoming number reduced to the sequence space
	assign seq_w  = SEQ_BITS'(seq_num);
	assign seq16  = PORT_SEQ_W'(seq_w);
	assign next16 = PORT_SEQ_W'(next_q);
	assign num16  = act.accepted ? next16 : seq16;
	assign cnt    = next_q - base_q;

	srsw_ctrl #(
		.WINDOW   (WINDOW),
		.SEQ_BITS (SEQ_BITS)
	) u_ctrl (
		.func        (func),
		.seq         (seq_w),
		.checksum_ok (checksum_ok),
		.base        (base_q),
		.next        (next_q),
		.head        (head_q),
		.valid       (valid_q),
		.acked       (acked_q),
		.act         (act),
		.slot        (slot),
		.base_nxt    (base_nxt),
		.next_nxt    (next_nxt),
		.head_nxt    (head_nxt),
		.valid_nxt   (valid_nxt),
		.acked_nxt   (acked_nxt)
	);

	// window state update on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= SEQ_BITS'(SEQ_INIT);
			next_q  <= SEQ_BITS'(SEQ_INIT);
			head_q  <= '0;
			valid_q <= '0;
			acked_q <= '0;
		end else if (accept) begin
			base_q  <= base_nxt;
			next_q  <= next_nxt;
			head_q  <= head_nxt;
			valid_q <= valid_nxt;
			acked_q <= acked_nxt;
		end
	end

	// payload memory: write on send, registered read on resend
	always_ff @(posedge clk) begin
		if (accept && act.mem_write) begin
			mem[slot] <= send_payload;
		end
		if (accept && act.mem_read) begin
			rd_q <= mem[slot];
		end
	end

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage one fields
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1     <= act;
			pseq_s1    <= act.packet_valid ? num16 : '0;
			tseq_s1    <= (act.timer_start || act.timer_stop) ? num16 : '0;
			base_s1    <= PORT_SEQ_W'(base_nxt);
			payload_s1 <= act.accepted ? send_payload : '0;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register fields, resend payload taken from the memory read
	always_ff @(posedge clk) begin
		if (move) begin
			accepted_q       <= act_s1.accepted;
			packet_valid_q   <= act_s1.packet_valid;
			packet_seq_q     <= pseq_s1;
			packet_payload_q <= act_s1.mem_read ? rd_q : payload_s1;
			timer_start_q    <= act_s1.timer_start;
			timer_stop_q     <= act_s1.timer_stop;
			timer_seq_q      <= tseq_s1;
			window_base_q    <= base_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = accepted_q;
	assign packet_valid   = packet_valid_q;
	assign packet_seq     = packet_seq_q;
	assign packet_payload = packet_payload_q;
	assign timer_start    = timer_start_q;
	assign timer_stop     = timer_stop_q;
	assign timer_seq      = timer_seq_q;
	assign window_base    = window_base_q;

	// occupancy never exceeds the window limit
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt <= SEQ_BITS'(LIMIT))
		else $error("window holds more packets than allowed");

	// one valid slot for each outstanding packet
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(cnt))
		else $error("slot valid bits disagree with occupancy");

	// only an outstanding slot can be marked acknowledged
	a_acked: assert property (@(posedge clk) disable iff (!arst_n)
		(acked_q & ~valid_q) == '0)
		else $error("acknowledged mark on an empty slot");

	// a result never asks to start and stop a timer together
	a_timer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(timer_start_q && timer_stop_q))
		else $error("timer start and stop in one word");

endmodule
